// File: rtl/core/http_body_deframer_defines.svh
// ---------------------------------------------------------------------------
// http_body_deframer_defines
// Assertion macros shared by the body deframer checkers.
// ---------------------------------------------------------------------------
`ifndef HTTP_BODY_DEFRAMER_DEFINES_SVH
`define HTTP_BODY_DEFRAMER_DEFINES_SVH

// Assert a property on a given clock, disabled while the reset is low
`define HBD_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Assert a property on the block clock and reset
`define HBD_ASSERT(lbl, prop, msg) `HBD_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: rtl/core/hbd_pkg.sv
// ---------------------------------------------------------------------------
// hbd_pkg
// Types and constants of the HTTP body deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 1'd1;

	// Body framing modes
	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_FIXED   = 2'd1;
	localparam logic [1:0] MODE_CHUNKED = 2'd2;
	localparam logic [1:0] MODE_UNSUP   = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_LF     = 3'd1;
	localparam logic [2:0] ST_BAD_CRLF  = 3'd2;
	localparam logic [2:0] ST_NO_DIGITS = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_UNSUP     = 3'd5;
	localparam logic [2:0] ST_AFTER_END = 3'd6;

	// Characters
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0b;
	localparam logic [7:0] CH_FF  = 8'h0c;
	localparam logic [7:0] CH_SP  = 8'h20;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_SIZE     = 3'd0,
		PH_LINE_LF  = 3'd1,
		PH_DATA     = 3'd2,
		PH_CHUNK_CR = 3'd3,
		PH_CHUNK_LF = 3'd4,
		PH_DONE     = 3'd5,
		PH_FAIL     = 3'd6
	} phase_t;

	// Classified input word
	typedef struct packed {
		logic [7:0] byte_v;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
		logic       is_blank;
	} cls_t;

	// Result word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       body_end;
		logic [2:0] status;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/core/hbd_if.sv
// ---------------------------------------------------------------------------
// hbd_if
// Stream channels of the body deframer: raw bytes in, decoded words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface hbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface hbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       body_end;
	logic [2:0] status;

	modport source (output valid, output data_byte, output data_valid,
		output body_end, output status, input ready);
	modport sink   (input valid, input data_byte, input data_valid,
		input body_end, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hbd_front.sv
// ---------------------------------------------------------------------------
// hbd_front
// Accepts raw body bytes and classifies each for the size line parser.
// ---------------------------------------------------------------------------
`default_nettype none

module hbd_front
	import hbd_pkg::*;
(
	hbd_in_if.sink     raw,
	input  wire logic  q_full,
	output cls_t       cls,
	output logic       push
);

	logic [7:0] c;

	assign c        = raw.in_byte;
	assign raw.ready = !q_full;
	assign push     = raw.valid && !q_full;

	// Classify the byte: hex digit, line characters, white space
	always_comb begin
		cls          = '0;
		cls.byte_v   = c;
		cls.is_cr    = (c == CH_CR);
		cls.is_lf    = (c == CH_LF);
		cls.is_blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_VT) || (c == CH_FF);
		if (c >= "0" && c <= "9") begin
			cls.hex_ok  = 1'b1;
			cls.hex_val = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			cls.hex_ok  = 1'b1;
			cls.hex_val = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			cls.hex_ok  = 1'b1;
			cls.hex_val = 4'(c - "A" + 8'd10);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/hbd_queue.sv
// ---------------------------------------------------------------------------
// hbd_queue
// Short queue of classified words between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module hbd_queue
	import hbd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cls_t      wr_word,
	input  wire logic pop,
	output cls_t      rd_word,
	output logic      not_empty,
	output logic      full
);

	cls_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign rd_word   = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/hbd_back.sv
// ---------------------------------------------------------------------------
// hbd_back
// Framing state machine: size line parse, payload count, chunk CRLF check,
// sticky errors, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module hbd_back
	import hbd_pkg::*;
#(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  cls_t                       cls,
	input  wire logic                  cls_valid,
	output logic                       cls_pop,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	hbd_out_if.source                  dec
);

	// Configuration and framing state
	logic [1:0]            mode_q,   mode_n;
	logic [CFG_DATA_W-1:0] length_q, length_n;
	phase_t                phase_q,  phase_n;
	logic [COUNT_BITS-1:0] left_q,   left_n;
	logic [COUNT_BITS-1:0] accum_q,  accum_n;
	logic                  seen_q,   seen_n;
	logic                  closed_q, closed_n;
	logic [2:0]            err_q,    err_n;

	// Output register
	logic                  out_valid_q;
	res_t                  res_q;
	res_t                  res;

	logic                  take;
	logic [63:0]           len_ext;
	logic [COUNT_BITS-1:0] len_cnt;
	logic [COUNT_BITS-1:0] left_dec;

	assign take    = cls_valid && (!out_valid_q || dec.ready);
	assign cls_pop = take;

	assign dec.valid      = out_valid_q;
	assign dec.data_byte  = res_q.data_byte;
	assign dec.data_valid = res_q.data_valid;
	assign dec.body_end   = res_q.body_end;
	assign dec.status     = res_q.status;

	assign left_dec = left_q - 1'b1;

	// Saturate the configured length to the counter range
	always_comb begin
		len_ext = 64'(length_n);
		if ((len_ext >> COUNT_BITS) != 64'd0) begin
			len_cnt = '1;
		end else begin
			len_cnt = len_ext[COUNT_BITS-1:0];
		end
	end

	// Register writes
	always_comb begin
		mode_n   = mode_q;
		length_n = length_q;
		if (cfg_we && cfg_index == REG_MODE) begin
			mode_n = cfg_wdata[1:0];
		end
		if (cfg_we && cfg_index == REG_LENGTH) begin
			length_n = cfg_wdata;
		end
	end

	// Next state of the framer and the result word
	always_comb begin
		phase_n  = phase_q;
		left_n   = left_q;
		accum_n  = accum_q;
		seen_n   = seen_q;
		closed_n = closed_q;
		err_n    = err_q;
		res      = '0;

		if (cfg_we) begin
			// Restart framing for the new register values
			accum_n  = '0;
			seen_n   = 1'b0;
			closed_n = 1'b0;
			err_n    = ST_OK;
			left_n   = '0;
			unique case (mode_n)
				MODE_FIXED: begin
					left_n  = len_cnt;
					phase_n = (len_cnt == '0) ? PH_DONE : PH_DATA;
				end
				MODE_CHUNKED: phase_n = PH_SIZE;
				MODE_UNSUP: begin
					phase_n = PH_FAIL;
					err_n   = ST_UNSUP;
				end
				default: phase_n = PH_DONE;
			endcase
		end else if (take) begin
			unique case (phase_q)
				PH_SIZE: begin
					if (cls.is_cr) begin
						phase_n = PH_LINE_LF;
					end else if (!closed_q) begin
						if (cls.hex_ok) begin
							if (accum_q[COUNT_BITS-1 -: 4] != 4'd0) begin
								phase_n = PH_FAIL;
								err_n   = ST_OVERFLOW;
							end else begin
								accum_n = {accum_q[COUNT_BITS-5:0], cls.hex_val};
								seen_n  = 1'b1;
							end
						end else if (!(cls.is_blank && !seen_q)) begin
							closed_n = 1'b1;
						end
					end
				end
				PH_LINE_LF: begin
					if (!cls.is_lf) begin
						phase_n = PH_FAIL;
						err_n   = ST_NO_LF;
					end else if (!seen_q) begin
						phase_n = PH_FAIL;
						err_n   = ST_NO_DIGITS;
					end else if (accum_q == '0) begin
						res.body_end = 1'b1;
						phase_n      = PH_DONE;
					end else begin
						left_n  = accum_q;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					res.data_byte  = cls.byte_v;
					res.data_valid = 1'b1;
					left_n         = left_dec;
					if (left_dec == '0) begin
						if (mode_q == MODE_CHUNKED) begin
							phase_n = PH_CHUNK_CR;
						end else begin
							res.body_end = 1'b1;
							phase_n      = PH_DONE;
						end
					end
				end
				PH_CHUNK_CR: begin
					if (!cls.is_cr) begin
						phase_n = PH_FAIL;
						err_n   = ST_BAD_CRLF;
					end else begin
						phase_n = PH_CHUNK_LF;
					end
				end
				PH_CHUNK_LF: begin
					if (!cls.is_lf) begin
						phase_n = PH_FAIL;
						err_n   = ST_BAD_CRLF;
					end else begin
						phase_n  = PH_SIZE;
						accum_n  = '0;
						seen_n   = 1'b0;
						closed_n = 1'b0;
					end
				end
				PH_DONE: begin
					phase_n = PH_FAIL;
					err_n   = ST_AFTER_END;
				end
				default: begin
					// Hold the sticky error
					phase_n = PH_FAIL;
					if (err_q == ST_OK) begin
						err_n = ST_AFTER_END;
					end
				end
			endcase
			res.status = err_n;
		end
	end

	// Framing state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			length_q <= '0;
			phase_q  <= PH_DONE;
			left_q   <= '0;
			accum_q  <= '0;
			seen_q   <= 1'b0;
			closed_q <= 1'b0;
			err_q    <= ST_OK;
		end else begin
			mode_q   <= mode_n;
			length_q <= length_n;
			phase_q  <= phase_n;
			left_q   <= left_n;
			accum_q  <= accum_n;
			seen_q   <= seen_n;
			closed_q <= closed_n;
			err_q    <= err_n;
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (dec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/http_body_deframer.sv
// A byte accepted at the input is written into the queue, then framed and registered as its result word.
// Throughput: one byte per cycle while the output is not stalled, set by the update of the back framing FSM.
// A two-word queue lets the byte input keep flowing while an output word waits, until the queue is full.
// Reset (arst_n low, asynchronous): mode none, length 0, framer in the done phase.
// A register write restarts framing at once and clears any sticky error.
// ---------------------------------------------------------------------------
// http_body_deframer
// HTTP message body deframer: fixed length or chunked transfer decoding.
// ---------------------------------------------------------------------------
`default_nettype none

module http_body_deframer
	import hbd_pkg::*;
#(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	hbd_in_if.sink                      raw,
	hbd_out_if.source                   dec,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cls_t front_word;
	cls_t head_word;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	// Accept and classify
	hbd_front u_front (
		.raw    (raw),
		.q_full (q_full),
		.cls    (front_word),
		.push   (push)
	);

	// Decouple front and back
	hbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_word   (front_word),
		.pop       (pop),
		.rd_word   (head_word),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// Frame and emit
	hbd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (head_word),
		.cls_valid (q_not_empty),
		.cls_pop   (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.dec       (dec)
	);

endmodule

`default_nettype wire

// File: rtl/core/hbd_checker.sv
// ---------------------------------------------------------------------------
// hbd_checker
// Port-level checks of the body deframer output words.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_body_deframer_defines.svh"

module hbd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       dec_valid,
	input wire logic       dec_ready,
	input wire logic [7:0] data_byte,
	input wire logic       data_valid,
	input wire logic       body_end,
	input wire logic [2:0] status
);

	// A stalled word holds
	`HBD_ASSERT(a_stall_hold, dec_valid && !dec_ready |=> dec_valid && $stable(data_byte) && $stable(status), "output word changed while stalled")

	// Non-payload words carry a zero byte
	`HBD_ASSERT(a_zero_byte, dec_valid && !data_valid |-> data_byte == 8'd0, "non-payload word carries a byte")

	// Payload and body end come only without error
	`HBD_ASSERT(a_ok_payload, dec_valid && (data_valid || body_end) |-> status == 3'd0, "payload or end flagged with error")

	// Status stays within its codes
	`HBD_ASSERT(a_status_range, dec_valid |-> status != 3'd7, "status code out of range")

endmodule

bind http_body_deframer hbd_checker u_hbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.dec_valid  (dec.valid),
	.dec_ready  (dec.ready),
	.data_byte  (dec.data_byte),
	.data_valid (dec.data_valid),
	.body_end   (dec.body_end),
	.status     (dec.status)
);

`default_nettype wire
